### hw/rtl/ebrq_pkg.sv
// Shared types and constants for the edge barrier release qualifier.
`timescale 1ns / 1ps
`default_nettype none

package ebrq_pkg;

  // Command codes carried by each input item
  typedef enum logic [1:0] {
    CmdHit     = 2'd0,
    CmdLeave   = 2'd1,
    CmdInstall = 2'd2,
    CmdRemove  = 2'd3
  } cmd_e;

  // Release modes (value 3 is unused and never releases)
  localparam logic [1:0] ModeSpeed     = 2'd0;
  localparam logic [1:0] ModeDistance  = 2'd1;
  localparam logic [1:0] ModeDoubleTap = 2'd2;

  // Barrier push directions
  localparam logic [1:0] DirPosX = 2'd0;
  localparam logic [1:0] DirNegX = 2'd1;
  localparam logic [1:0] DirPosY = 2'd2;
  localparam logic [1:0] DirNegY = 2'd3;

  // Register map: one word per register, selected by paddr[2]
  localparam int unsigned ApbAddrW   = 3;
  localparam logic        RegMode      = 1'b0;
  localparam logic        RegThreshold = 1'b1;

  // Reset values: distance mode, 50.0 pixels in Q11.4
  localparam logic [1:0]  ModeReset      = ModeDistance;
  localparam logic [31:0] ThresholdReset = 32'd800;

  // barrier_index is four bits, so at most sixteen entries are addressable
  localparam int unsigned MaxEntries = 16;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  barrier_index;
    logic [1:0]  edge_direction;
    logic [15:0] move_x;
    logic [15:0] move_y;
    logic [31:0] time_now;
    logic [15:0] device_tag;
    logic [31:0] event_tag;
  } evt_t;

  typedef struct packed {
    logic        release_now;
    logic        entry_known;
    logic [3:0]  barrier_out;
    logic [15:0] device_out;
    logic [31:0] event_out;
  } res_t;

  typedef struct packed {
    logic [1:0]  release_mode;
    logic [31:0] release_threshold;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/ebrq_if.sv
// Valid/ready channel interfaces for event items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface ebrq_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  barrier_index;
  logic [1:0]  edge_direction;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;
  logic [31:0] time_now;
  logic [15:0] device_tag;
  logic [31:0] event_tag;

  modport source (
    output valid, cmd, barrier_index, edge_direction, move_x, move_y,
           time_now, device_tag, event_tag,
    input  ready
  );
  modport sink (
    input  valid, cmd, barrier_index, edge_direction, move_x, move_y,
           time_now, device_tag, event_tag,
    output ready
  );
endinterface

interface ebrq_res_if;
  logic        valid;
  logic        ready;
  logic        release_now;
  logic        entry_known;
  logic [3:0]  barrier_out;
  logic [15:0] device_out;
  logic [31:0] event_out;

  modport source (
    output valid, release_now, entry_known, barrier_out, device_out, event_out,
    input  ready
  );
  modport sink (
    input  valid, release_now, entry_known, barrier_out, device_out, event_out,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/ebrq_cfg.sv
// APB configuration registers: release mode and release threshold.
`timescale 1ns / 1ps
`default_nettype none

module ebrq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ebrq_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ebrq_pkg::cfg_t                cfg_o
);
  import ebrq_pkg::*;

  logic [1:0]  mode_q;
  logic [31:0] thr_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
      thr_q  <= ThresholdReset;
    end else if (wr_en) begin
      case (paddr[2])
        RegMode:      mode_q <= pwdata[1:0];
        RegThreshold: thr_q  <= pwdata;
        default:      ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[2])
      RegMode:      prdata = {30'd0, mode_q};
      RegThreshold: prdata = thr_q;
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.release_mode      = mode_q;
  assign cfg_o.release_threshold = thr_q;

endmodule

`default_nettype wire

### hw/rtl/ebrq_core.sv
// Barrier table and release decision: one read-modify-write per item.
`timescale 1ns / 1ps
`default_nettype none

module ebrq_core #(
  parameter int unsigned NUM_BARRIERS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ebrq_pkg::evt_t evt_i,
  input  ebrq_pkg::cfg_t cfg_i,
  input  logic           we_i,
  output logic           release_o,
  output logic           known_o
);
  import ebrq_pkg::*;

  // Only indices below sixteen can ever be addressed
  localparam int unsigned Depth = (NUM_BARRIERS < MaxEntries) ? NUM_BARRIERS : MaxEntries;
  localparam int unsigned EntW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [8:0]  NumLimit = 9'(NUM_BARRIERS);

  // Table storage; only the valid flags are reset
  logic        valid_q    [Depth];
  logic [1:0]  dir_q      [Depth];
  logic [31:0] total_q    [Depth];
  logic [31:0] tap_time_q [Depth];
  logic        tap_tv_q   [Depth];
  logic        armed_q    [Depth];

  logic            in_range;
  logic [EntW-1:0] ent;
  logic            known;
  logic [1:0]      rd_dir;
  logic [31:0]     rd_total;
  logic [31:0]     rd_tap_time;
  logic            rd_tap_tv;
  logic            rd_armed;

  logic signed [16:0] mx17;
  logic signed [16:0] my17;
  logic signed [16:0] push;
  logic [31:0]        push_u;
  logic [32:0]        sum_wide;
  logic [31:0]        sum_sat;
  logic [31:0]        elapsed;

  logic        rel;
  logic [31:0] total_d;
  logic [31:0] tap_time_d;
  logic        tap_tv_d;
  logic        armed_d;
  logic [1:0]  dir_d;

  // Addressing
  assign in_range = {5'd0, evt_i.barrier_index} < NumLimit;
  assign ent      = in_range ? evt_i.barrier_index[EntW-1:0] : '0;
  assign known    = in_range && valid_q[ent];

  assign rd_dir      = dir_q[ent];
  assign rd_total    = total_q[ent];
  assign rd_tap_time = tap_time_q[ent];
  assign rd_tap_tv   = tap_tv_q[ent];
  assign rd_armed    = armed_q[ent];

  // Push toward the barrier, exact in 17 bits
  assign mx17 = {evt_i.move_x[15], evt_i.move_x};
  assign my17 = {evt_i.move_y[15], evt_i.move_y};

  always_comb begin
    case (rd_dir)
      DirPosX: push = -mx17;
      DirNegX: push = mx17;
      DirPosY: push = -my17;
      default: push = my17;
    endcase
  end

  assign push_u   = {16'd0, push[15:0]};
  assign sum_wide = {1'b0, rd_total} + {1'b0, push_u};
  assign sum_sat  = sum_wide[32] ? '1 : sum_wide[31:0];
  assign elapsed  = evt_i.time_now - rd_tap_time;

  // Next entry contents and release decision
  always_comb begin
    rel        = 1'b0;
    total_d    = rd_total;
    tap_time_d = rd_tap_time;
    tap_tv_d   = rd_tap_tv;
    armed_d    = rd_armed;
    dir_d      = rd_dir;
    case (evt_i.cmd)
      CmdHit: begin
        if (known && !push[16]) begin
          case (cfg_i.release_mode)
            ModeSpeed: rel = push_u > cfg_i.release_threshold;
            ModeDistance: begin
              rel     = sum_sat > cfg_i.release_threshold;
              total_d = rel ? '0 : sum_sat;
            end
            ModeDoubleTap: begin
              if (!rd_armed) begin
                rel = rd_tap_tv && (elapsed < cfg_i.release_threshold);
                if (!rel) begin
                  tap_time_d = evt_i.time_now;
                  tap_tv_d   = 1'b1;
                  armed_d    = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      CmdLeave: begin
        if (known) begin
          case (cfg_i.release_mode)
            ModeDistance:  total_d = '0;
            ModeDoubleTap: armed_d = 1'b0;
            default:       ;
          endcase
        end
      end
      CmdInstall: begin
        dir_d      = evt_i.edge_direction;
        total_d    = '0;
        tap_time_d = '0;
        tap_tv_d   = 1'b0;
        armed_d    = 1'b0;
      end
      default: ;
    endcase
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (we_i && in_range) begin
      if (evt_i.cmd == CmdInstall) begin
        valid_q[ent] <= 1'b1;
      end else if (evt_i.cmd == CmdRemove) begin
        valid_q[ent] <= 1'b0;
      end
    end
  end

  // Entry payload write-back
  always_ff @(posedge clk_i) begin
    if (we_i && in_range) begin
      dir_q[ent]      <= dir_d;
      total_q[ent]    <= total_d;
      tap_time_q[ent] <= tap_time_d;
      tap_tv_q[ent]   <= tap_tv_d;
      armed_q[ent]    <= armed_d;
    end
  end

  assign release_o = rel;
  assign known_o   = known;

  // A release only comes from a hit on an installed entry
  a_rel_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel |-> (known && evt_i.cmd == CmdHit))
    else $error("release without a hit on a known entry");

  // An install marks the entry valid from the next item on
  a_install_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_i && in_range && evt_i.cmd == CmdInstall) |=> valid_q[$past(ent)])
    else $error("install did not mark entry valid");

  // A remove frees the entry
  a_remove_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_i && in_range && evt_i.cmd == CmdRemove) |=> !valid_q[$past(ent)])
    else $error("remove did not free entry");

endmodule

`default_nettype wire

### hw/rtl/edge_barrier_release_qualifier.sv
// Top level: input register, barrier table core, result register, APB registers.
// Path: an accepted item waits in the input register and moves into the result register
//   when the result slot is free, that is when it is empty or its result is being taken.
// Throughput: one item per cycle while the result channel is not stalled; the table is
//   updated in the same cycle that the result register loads, so back-to-back items on one entry see fresh state.
// Reset: asynchronous, active low; clears pipeline valids and all entry valid
//   flags, sets release_mode to 1 and release_threshold to 800.
`timescale 1ns / 1ps
`default_nettype none

module edge_barrier_release_qualifier #(
  parameter int unsigned NUM_BARRIERS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ebrq_evt_if.sink                      evt_i,
  ebrq_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ebrq_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ebrq_pkg::*;

  cfg_t cfg;
  evt_t s1_q;
  logic s1_valid_q;
  logic s1_valid_d;
  res_t res_q;
  logic res_valid_q;
  logic res_valid_d;
  logic advance;
  logic take_in;
  logic rel;
  logic known;

  ebrq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the item in the input register moves on when the result slot frees
  assign advance     = s1_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !s1_valid_q || advance;
  assign take_in     = evt_i.valid && evt_i.ready;
  assign s1_valid_d  = take_in || (s1_valid_q && !advance);
  assign res_valid_d = advance || (res_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_q.cmd            <= cmd_e'(evt_i.cmd);
      s1_q.barrier_index  <= evt_i.barrier_index;
      s1_q.edge_direction <= evt_i.edge_direction;
      s1_q.move_x         <= evt_i.move_x;
      s1_q.move_y         <= evt_i.move_y;
      s1_q.time_now       <= evt_i.time_now;
      s1_q.device_tag     <= evt_i.device_tag;
      s1_q.event_tag      <= evt_i.event_tag;
    end
  end

  ebrq_core #(
    .NUM_BARRIERS (NUM_BARRIERS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (s1_q),
    .cfg_i     (cfg),
    .we_i      (advance),
    .release_o (rel),
    .known_o   (known)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.release_now <= rel;
      res_q.entry_known <= known;
      res_q.barrier_out <= s1_q.barrier_index;
      res_q.device_out  <= s1_q.device_tag;
      res_q.event_out   <= s1_q.event_tag;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.release_now = res_q.release_now;
  assign res_o.entry_known = res_q.entry_known;
  assign res_o.barrier_out = res_q.barrier_out;
  assign res_o.device_out  = res_q.device_out;
  assign res_o.event_out   = res_q.event_out;

endmodule

`default_nettype wire

### sim/edge_barrier_release_qualifier_tb.sv
// Self-checking testbench for the edge barrier release qualifier, with a table predictor.
`timescale 1ns / 1ps

module edge_barrier_release_qualifier_tb;
  import ebrq_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  ebrq_evt_if evt_bus ();
  ebrq_res_if res_bus ();

  edge_barrier_release_qualifier #(
    .NUM_BARRIERS(ENTRIES)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt_bus),
    .res_o  (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk = ~clk;

  // Predictor copy of the configuration and of the barrier table
  logic [1:0]  run_mode;
  logic [31:0] run_thresh;
  logic        bar_live     [ENTRIES];
  logic [1:0]  bar_dir      [ENTRIES];
  logic [31:0] bar_push_sum [ENTRIES];
  logic [31:0] bar_tap_time [ENTRIES];
  logic        bar_tap_seen [ENTRIES];
  logic        bar_armed    [ENTRIES];

  evt_t        event_q[$];
  res_t        verdict_q[$];
  evt_t        on_bus;
  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned quiet_cycles;
  int unsigned fails;
  int unsigned send_idle_pct;
  int unsigned sink_idle_pct;
  logic [31:0] clock_us;
  int unsigned tick_span;

  // Expected verdict for one event; updates the predicted table
  function automatic res_t qualify_event(input evt_t e);
    res_t               r;
    int unsigned        k;
    logic               known;
    logic               fire;
    logic signed [16:0] push;
    logic [31:0]        amount;
    logic [32:0]        total;
    logic [31:0]        gap;
    k     = {28'd0, e.barrier_index};
    known = bar_live[k];
    fire  = 1'b0;
    case (e.cmd)
      CmdHit: begin
        if (known) begin
          case (bar_dir[k])
            DirPosX: push = -$signed({e.move_x[15], e.move_x});
            DirNegX: push = $signed({e.move_x[15], e.move_x});
            DirPosY: push = -$signed({e.move_y[15], e.move_y});
            default: push = $signed({e.move_y[15], e.move_y});
          endcase
          // a push away from the barrier is ignored
          if (!push[16]) begin
            amount = {15'd0, push[16:0]};
            case (run_mode)
              ModeSpeed: fire = amount > run_thresh;
              ModeDistance: begin
                total = {1'b0, bar_push_sum[k]} + {1'b0, amount};
                bar_push_sum[k] = total[32] ? 32'hFFFF_FFFF : total[31:0];
                fire = bar_push_sum[k] > run_thresh;
                if (fire) bar_push_sum[k] = '0;
              end
              ModeDoubleTap: begin
                if (!bar_armed[k]) begin
                  gap  = e.time_now - bar_tap_time[k];
                  fire = bar_tap_seen[k] && (gap < run_thresh);
                  if (!fire) begin
                    bar_tap_time[k] = e.time_now;
                    bar_tap_seen[k] = 1'b1;
                    bar_armed[k]    = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      CmdLeave: begin
        if (known) begin
          if (run_mode == ModeDistance) bar_push_sum[k] = '0;
          else if (run_mode == ModeDoubleTap) bar_armed[k] = 1'b0;
        end
      end
      CmdInstall: begin
        bar_live[k]     = 1'b1;
        bar_dir[k]      = e.edge_direction;
        bar_push_sum[k] = '0;
        bar_tap_time[k] = '0;
        bar_tap_seen[k] = 1'b0;
        bar_armed[k]    = 1'b0;
      end
      default: bar_live[k] = 1'b0;
    endcase
    r.release_now = fire;
    r.entry_known = known;
    r.barrier_out = e.barrier_index;
    r.device_out  = e.device_tag;
    r.event_out   = e.event_tag;
    return r;
  endfunction

  // Moves: mostly small either way, some extremes, some anything
  function automatic logic [15:0] pick_move();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      3:       return '0;
      default: return 16'($urandom_range(6000)) - 16'd3000;
    endcase
  endfunction

  // Random event, biased towards a few entries so sequences build up state
  function automatic evt_t make_event();
    evt_t        e;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)      e.cmd = CmdHit;
    else if (pick < 72) e.cmd = CmdLeave;
    else if (pick < 90) e.cmd = CmdInstall;
    else                e.cmd = CmdRemove;
    e.barrier_index  = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    e.edge_direction = 2'($urandom);
    e.move_x         = pick_move();
    e.move_y         = pick_move();
    clock_us         = clock_us + $urandom_range(tick_span);
    e.time_now       = ($urandom_range(15) == 0) ? $urandom : clock_us;
    e.device_tag     = 16'($urandom);
    e.event_tag      = $urandom;
    return e;
  endfunction

  // Directed event with extreme tags and times
  task automatic add_event(input cmd_e c, input logic [3:0] idx, input logic [1:0] dir,
                           input logic [15:0] mx, input logic [15:0] my);
    evt_t e;
    e.cmd            = c;
    e.barrier_index  = idx;
    e.edge_direction = dir;
    e.move_x         = mx;
    e.move_y         = my;
    e.time_now       = queued_cnt[0] ? 32'hFFFF_FFFF : 32'd0;
    e.device_tag     = queued_cnt[0] ? 16'd0 : 16'hFFFF;
    e.event_tag      = queued_cnt[1] ? 32'hFFFF_FFFF : 32'd0;
    event_q.push_back(e);
    queued_cnt++;
  endtask

  task automatic wait_all_results();
    while (accepted_cnt != queued_cnt || verdict_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic sel, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == RegMode) run_mode = value[1:0];
    else run_thresh = value;
  endtask

  // One random phase under fixed settings; optionally pauses half way
  task automatic run_phase(input logic [1:0] mode, input logic [31:0] thresh,
                           input int unsigned tick, input int unsigned count,
                           input int unsigned send_pct, input int unsigned sink_pct,
                           input logic split);
    wait_all_results();
    repeat (4) @(posedge clk);
    write_reg(RegMode, {30'd0, mode});
    write_reg(RegThreshold, thresh);
    send_idle_pct = send_pct;
    sink_idle_pct = sink_pct;
    tick_span     = tick;
    for (int unsigned n = 0; n < count; n++) begin
      if (split && n == count / 2) wait_all_results();
      event_q.push_back(make_event());
      queued_cnt++;
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fails++;
    end
  endtask

  // Driver: one item held on the channel until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      evt_bus.valid <= 1'b0;
    end else begin
      if (evt_bus.valid && evt_bus.ready) begin
        verdict_q.push_back(qualify_event(on_bus));
        accepted_cnt++;
      end
      if (!evt_bus.valid || evt_bus.ready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus                 = event_q.pop_front();
          evt_bus.valid          <= 1'b1;
          evt_bus.cmd            <= on_bus.cmd;
          evt_bus.barrier_index  <= on_bus.barrier_index;
          evt_bus.edge_direction <= on_bus.edge_direction;
          evt_bus.move_x         <= on_bus.move_x;
          evt_bus.move_y         <= on_bus.move_y;
          evt_bus.time_now       <= on_bus.time_now;
          evt_bus.device_tag     <= on_bus.device_tag;
          evt_bus.event_tag      <= on_bus.event_tag;
        end else begin
          evt_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result item against the oldest verdict
  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual event %0h",
                   $time, res_bus.event_out);
          fails++;
        end else begin
          compare_field("release_now", {31'd0, verdict_q[0].release_now},
                        {31'd0, res_bus.release_now});
          compare_field("entry_known", {31'd0, verdict_q[0].entry_known},
                        {31'd0, res_bus.entry_known});
          compare_field("barrier_out", {28'd0, verdict_q[0].barrier_out},
                        {28'd0, res_bus.barrier_out});
          compare_field("device_out", {16'd0, verdict_q[0].device_out},
                        {16'd0, res_bus.device_out});
          compare_field("event_out", verdict_q[0].event_out, res_bus.event_out);
          void'(verdict_q.pop_front());
        end
      end
      if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus sequence
  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    evt_bus.valid  = 1'b0;
    evt_bus.cmd    = CmdHit;
    evt_bus.barrier_index  = '0;
    evt_bus.edge_direction = '0;
    evt_bus.move_x         = '0;
    evt_bus.move_y         = '0;
    evt_bus.time_now       = '0;
    evt_bus.device_tag     = '0;
    evt_bus.event_tag      = '0;
    res_bus.ready  = 1'b0;
    run_mode       = ModeReset;
    run_thresh     = ThresholdReset;
    queued_cnt     = 0;
    accepted_cnt   = 0;
    fails          = 0;
    send_idle_pct  = 20;
    sink_idle_pct  = 56;
    tick_span      = 5000;
    clock_us       = $urandom;
    for (int i = 0; i < ENTRIES; i++) begin
      bar_live[i]     = 1'b0;
      bar_dir[i]      = '0;
      bar_push_sum[i] = '0;
      bar_tap_time[i] = '0;
      bar_tap_seen[i] = 1'b0;
      bar_armed[i]    = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unknown entry, all commands, push extremes, distance build-up
    add_event(CmdHit, 4'd5, DirPosX, 16'h8000, 16'h8000);
    add_event(CmdLeave, 4'd5, DirPosX, 16'd0, 16'd0);
    add_event(CmdRemove, 4'd5, DirPosX, 16'd0, 16'd0);
    add_event(CmdInstall, 4'd0, DirPosX, 16'd0, 16'd0);
    add_event(CmdHit, 4'd0, DirNegY, 16'h8000, 16'h7FFF);
    add_event(CmdHit, 4'd0, DirPosX, 16'h7FFF, 16'h0000);
    add_event(CmdHit, 4'd0, DirPosX, 16'h0000, 16'h8000);
    add_event(CmdHit, 4'd0, DirPosX, -16'sd400, 16'd0);
    add_event(CmdHit, 4'd0, DirPosX, -16'sd400, 16'd0);
    add_event(CmdHit, 4'd0, DirPosX, 16'hFFFF, 16'd0);
    add_event(CmdInstall, 4'd15, DirNegX, 16'd0, 16'd0);
    add_event(CmdHit, 4'd15, DirPosX, 16'h7FFF, 16'h8000);
    add_event(CmdInstall, 4'd1, DirPosY, 16'd0, 16'd0);
    add_event(CmdHit, 4'd1, DirPosX, 16'd0, -16'sd500);
    add_event(CmdLeave, 4'd1, DirPosX, 16'd0, 16'd0);
    add_event(CmdHit, 4'd1, DirPosX, 16'd0, -16'sd500);
    add_event(CmdInstall, 4'd2, DirNegY, 16'd0, 16'd0);
    add_event(CmdHit, 4'd2, DirPosX, 16'h8000, 16'h7FFF);
    add_event(CmdHit, 4'd2, DirPosX, 16'd0, 16'h8000);
    add_event(CmdInstall, 4'd0, DirNegY, 16'd0, 16'd0);
    add_event(CmdHit, 4'd0, DirPosX, 16'd0, 16'd600);
    add_event(CmdRemove, 4'd0, DirPosX, 16'd0, 16'd0);
    add_event(CmdHit, 4'd0, DirPosX, 16'd0, 16'h7FFF);

    // Random phases across modes and threshold extremes
    run_phase(ModeDistance, 32'd800, 5000, 260, 20, 56, 1'b1);
    run_phase(ModeSpeed, $urandom_range(2500, 100), 5000, 250, 20, 56, 1'b0);
    run_phase(ModeDoubleTap, 32'd1000, 1500, 250, 20, 56, 1'b0);
    run_phase(ModeDistance, 32'd0, 5000, 200, 56, 20, 1'b0);
    run_phase(ModeSpeed, 32'hFFFF_FFFF, 5000, 150, 56, 20, 1'b0);
    run_phase(ModeDoubleTap, 32'hFFFF_FFFF, 100000, 150, 56, 20, 1'b0);
    run_phase(ModeDoubleTap, 32'd0, 1000, 150, 0, 0, 1'b0);
    run_phase(ModeSpeed, 32'd0, 5000, 150, 0, 0, 1'b0);
    run_phase(ModeDistance, 32'd20000, 5000, 200, 0, 0, 1'b0);
    run_phase(ModeDoubleTap, 32'd50000, 60000, 190, 0, 0, 1'b0);

    wait_all_results();
    repeat (8) @(posedge clk);
    if (fails == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ebrq_pkg.sv
hw/rtl/ebrq_if.sv
hw/rtl/ebrq_cfg.sv
hw/rtl/ebrq_core.sv
hw/rtl/edge_barrier_release_qualifier.sv
sim/edge_barrier_release_qualifier_tb.sv
